[design/dpw_pkg.sv]
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared constants and types for the depth pixel to world point pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int COORD_W = 24;  // world coordinate, signed, 1/16 mm
    localparam int DIFF_W  = 18;  // pixel offset from optical centre, signed Q14.4
    localparam int PIX_W   = 35;  // offset * depth
    localparam int FOC_W   = 60;  // offset * depth * reciprocal focal length
    localparam int CAM_W   = 34;  // camera coordinate, signed, 1/16 mm
    localparam int COEF_W  = 16;  // rotation entry, signed Q2.14
    localparam int PROD_W  = 50;  // rotation entry * camera coordinate
    localparam int ACC_W   = 52;  // sum of three products
    localparam int SUM_W   = 38;  // rotated coordinate, rounded
    localparam int WORLD_W = 39;  // rotated coordinate plus translation
    localparam int TRANS_W = 21;

    localparam logic [2:0] REG_INV_FX  = 3'd0;
    localparam logic [2:0] REG_INV_FY  = 3'd1;
    localparam logic [2:0] REG_CENTER  = 3'd2;
    localparam logic [2:0] REG_DLIMIT  = 3'd3;
    localparam logic [2:0] REG_ROT_X   = 3'd4;
    localparam logic [2:0] REG_ROT_Y   = 3'd5;
    localparam logic [2:0] REG_ROT_Z   = 3'd6;
    localparam logic [2:0] REG_TRANS   = 3'd7;

    typedef struct packed {
        logic [23:0] inv_fx;
        logic [23:0] inv_fy;
        logic [31:0] center;
        logic [15:0] depth_limit;
        logic [47:0] rot_x;
        logic [47:0] rot_y;
        logic [47:0] rot_z;
        logic [62:0] translation;
    } cfg_t;

    typedef struct packed {
        logic signed [CAM_W-1:0] x;
        logic signed [CAM_W-1:0] y;
        logic signed [CAM_W-1:0] z;
        logic [7:0]              blue;
        logic [7:0]              green;
        logic [7:0]              red;
    } cam_point_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
        logic [7:0]              blue;
        logic [7:0]              green;
        logic [7:0]              red;
    } sum_point_t;

endpackage

[design/dpw_cam.sv]
// ----------------------------------------------------------------------------
// dpw_cam
// Back-projection of a pixel to camera coordinates, three register stages.
// ----------------------------------------------------------------------------
module dpw_cam (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               take,
    input  logic [9:0]         pixel_row,
    input  logic [9:0]         pixel_column,
    input  logic [15:0]        depth_mm,
    input  logic [7:0]         blue_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         red_in,
    input  dpw_pkg::cfg_t      cfg,
    output logic               cam_valid,
    output dpw_pkg::cam_point_t cam
);

    localparam logic signed [dpw_pkg::FOC_W-1:0] HALF_LSB = 60'sd8388608;

    logic                               s1_valid_reg;
    logic signed [dpw_pkg::DIFF_W-1:0]  s1_dx_reg;
    logic signed [dpw_pkg::DIFF_W-1:0]  s1_ndy_reg;
    logic [15:0]                        s1_depth_reg;
    logic [23:0]                        s1_rgb_reg;

    logic                               s2_valid_reg;
    logic signed [dpw_pkg::PIX_W-1:0]   s2_px_reg;
    logic signed [dpw_pkg::PIX_W-1:0]   s2_py_reg;
    logic [15:0]                        s2_depth_reg;
    logic [23:0]                        s2_rgb_reg;

    logic                               s3_valid_reg;
    dpw_pkg::cam_point_t                s3_cam_reg;

    logic signed [dpw_pkg::DIFF_W-1:0]  dx_next;
    logic signed [dpw_pkg::DIFF_W-1:0]  ndy_next;
    logic signed [dpw_pkg::FOC_W-1:0]   fx_full;
    logic signed [dpw_pkg::FOC_W-1:0]   fy_full;
    logic signed [dpw_pkg::FOC_W-1:0]   fx_rnd;
    logic signed [dpw_pkg::FOC_W-1:0]   fy_rnd;

    // pixel index as Q12.4 against the optical centre; Y axis flipped
    assign dx_next  = $signed({4'b0, pixel_column, 4'b0}) - $signed({2'b0, cfg.center[15:0]});
    assign ndy_next = $signed({2'b0, cfg.center[31:16]}) - $signed({4'b0, pixel_row, 4'b0});

    assign fx_full = dpw_pkg::FOC_W'(s2_px_reg)
                   * dpw_pkg::FOC_W'($signed({1'b0, cfg.inv_fx}));
    assign fy_full = dpw_pkg::FOC_W'(s2_py_reg)
                   * dpw_pkg::FOC_W'($signed({1'b0, cfg.inv_fy}));
    assign fx_rnd  = fx_full + HALF_LSB;
    assign fy_rnd  = fy_full + HALF_LSB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dx_reg    <= dx_next;
            s1_ndy_reg   <= ndy_next;
            s1_depth_reg <= depth_mm;
            s1_rgb_reg   <= {blue_in, green_in, red_in};

            s2_px_reg    <= dpw_pkg::PIX_W'(s1_dx_reg)
                          * dpw_pkg::PIX_W'($signed({1'b0, s1_depth_reg}));
            s2_py_reg    <= dpw_pkg::PIX_W'(s1_ndy_reg)
                          * dpw_pkg::PIX_W'($signed({1'b0, s1_depth_reg}));
            s2_depth_reg <= s1_depth_reg;
            s2_rgb_reg   <= s1_rgb_reg;

            // round half up, drop the 24 fraction bits
            s3_cam_reg.x     <= fx_rnd[24 +: dpw_pkg::CAM_W];
            s3_cam_reg.y     <= fy_rnd[24 +: dpw_pkg::CAM_W];
            s3_cam_reg.z     <= $signed({14'b0, s2_depth_reg, 4'b0});
            s3_cam_reg.blue  <= s2_rgb_reg[23:16];
            s3_cam_reg.green <= s2_rgb_reg[15:8];
            s3_cam_reg.red   <= s2_rgb_reg[7:0];
        end
    end

    assign cam_valid = s3_valid_reg;
    assign cam       = s3_cam_reg;

endmodule

[design/dpw_rigid.sv]
// ----------------------------------------------------------------------------
// dpw_rigid
// Rotation of the camera point: nine products, then rounded row sums.
// ----------------------------------------------------------------------------
module dpw_rigid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                cam_valid,
    input  dpw_pkg::cam_point_t cam,
    input  dpw_pkg::cfg_t       cfg,
    output logic                sum_valid,
    output dpw_pkg::sum_point_t sum
);

    localparam logic signed [dpw_pkg::ACC_W-1:0] HALF_LSB = 52'sd8192;

    logic                               s4_valid_reg;
    logic signed [dpw_pkg::PROD_W-1:0]  s4_prod_reg [3][3];
    logic [23:0]                        s4_rgb_reg;

    logic                               s5_valid_reg;
    dpw_pkg::sum_point_t                s5_sum_reg;

    logic [47:0]                        rows [3];
    logic signed [dpw_pkg::CAM_W-1:0]   cam_c [3];
    logic signed [dpw_pkg::ACC_W-1:0]   acc [3];

    assign rows[0]  = cfg.rot_x;
    assign rows[1]  = cfg.rot_y;
    assign rows[2]  = cfg.rot_z;
    assign cam_c[0] = cam.x;
    assign cam_c[1] = cam.y;
    assign cam_c[2] = cam.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = dpw_pkg::ACC_W'(s4_prod_reg[i][0]) + dpw_pkg::ACC_W'(s4_prod_reg[i][1])
                   + dpw_pkg::ACC_W'(s4_prod_reg[i][2]) + HALF_LSB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_valid_reg <= cam_valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s4_prod_reg[i][j] <=
                        dpw_pkg::PROD_W'($signed(rows[i][16*j +: dpw_pkg::COEF_W]))
                        * dpw_pkg::PROD_W'(cam_c[j]);
                end
            end
            s4_rgb_reg <= {cam.blue, cam.green, cam.red};

            // Q2.14 coefficients: round half up, drop 14 fraction bits
            s5_sum_reg.x     <= acc[0][14 +: dpw_pkg::SUM_W];
            s5_sum_reg.y     <= acc[1][14 +: dpw_pkg::SUM_W];
            s5_sum_reg.z     <= acc[2][14 +: dpw_pkg::SUM_W];
            s5_sum_reg.blue  <= s4_rgb_reg[23:16];
            s5_sum_reg.green <= s4_rgb_reg[15:8];
            s5_sum_reg.red   <= s4_rgb_reg[7:0];
        end
    end

    assign sum_valid = s5_valid_reg;
    assign sum       = s5_sum_reg;

endmodule

[design/depth_pixel_to_world_point.sv]
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Back-projects depth pixels and moves them into world coordinates.
// ----------------------------------------------------------------------------
// A pixel goes through s1 to s3 in dpw_cam, s4 and s5 in dpw_rigid, then out_valid_reg.
// Throughput: 1 pixel per cycle while no result waits; six register stages,
// one multiplier rank in each of the offset, focal and rotation steps.
// A waiting result holds the whole pipeline; pixels with no result leave a bubble.
// Reset: all valid bits cleared, configuration registers to their default camera model.
module depth_pixel_to_world_point (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  pixel_row,
    input  logic [9:0]  pixel_column,
    input  logic [15:0] depth_mm,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  red_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [23:0] world_x,
    output logic signed [23:0] world_y,
    output logic signed [23:0] world_z,
    output logic [7:0]  blue_out,
    output logic [7:0]  green_out,
    output logic [7:0]  red_out
);

    localparam logic signed [dpw_pkg::WORLD_W-1:0] SAT_MAX = 39'sd8388607;
    localparam logic signed [dpw_pkg::WORLD_W-1:0] SAT_MIN = -39'sd8388608;

    dpw_pkg::cfg_t        cfg_reg;
    logic                 out_valid_reg;
    logic signed [dpw_pkg::COORD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic [23:0]          rgb_reg;

    logic                 advance;
    logic                 keep;
    logic                 take;
    logic                 cam_valid;
    dpw_pkg::cam_point_t  cam;
    logic                 sum_valid;
    dpw_pkg::sum_point_t  sum;

    logic signed [dpw_pkg::WORLD_W-1:0] wx_next, wy_next, wz_next;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_fx      <= 24'd27192;
            cfg_reg.inv_fy      <= 24'd27136;
            cfg_reg.center      <= 32'd248779771;
            cfg_reg.depth_limit <= 16'd1200;
            cfg_reg.rot_x       <= 48'h0000_0000_4000;
            cfg_reg.rot_y       <= 48'h0000_4000_0000;
            cfg_reg.rot_z       <= 48'h4000_0000_0000;
            cfg_reg.translation <= 63'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dpw_pkg::REG_INV_FX: cfg_reg.inv_fx      <= cfg_data[23:0];
                dpw_pkg::REG_INV_FY: cfg_reg.inv_fy      <= cfg_data[23:0];
                dpw_pkg::REG_CENTER: cfg_reg.center      <= cfg_data[31:0];
                dpw_pkg::REG_DLIMIT: cfg_reg.depth_limit <= cfg_data[15:0];
                dpw_pkg::REG_ROT_X:  cfg_reg.rot_x       <= cfg_data[47:0];
                dpw_pkg::REG_ROT_Y:  cfg_reg.rot_y       <= cfg_data[47:0];
                dpw_pkg::REG_ROT_Z:  cfg_reg.rot_z       <= cfg_data[47:0];
                dpw_pkg::REG_TRANS:  cfg_reg.translation <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    assign keep = (depth_mm != 16'd0) && (depth_mm < cfg_reg.depth_limit)
               && (32'(pixel_row) < dpw_pkg::MAX_ROWS)
               && (32'(pixel_column) < dpw_pkg::MAX_COLUMNS);
    assign take = in_valid && keep;

    dpw_cam u_cam (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .take         (take),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .depth_mm     (depth_mm),
        .blue_in      (blue_in),
        .green_in     (green_in),
        .red_in       (red_in),
        .cfg          (cfg_reg),
        .cam_valid    (cam_valid),
        .cam          (cam)
    );

    dpw_rigid u_rigid (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cam_valid (cam_valid),
        .cam       (cam),
        .cfg       (cfg_reg),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // ------------------------------------------------ translation, saturation
    assign wx_next = dpw_pkg::WORLD_W'(sum.x)
                   + dpw_pkg::WORLD_W'($signed(cfg_reg.translation[20:0]));
    assign wy_next = dpw_pkg::WORLD_W'(sum.y)
                   + dpw_pkg::WORLD_W'($signed(cfg_reg.translation[41:21]));
    assign wz_next = dpw_pkg::WORLD_W'(sum.z)
                   + dpw_pkg::WORLD_W'($signed(cfg_reg.translation[62:42]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wx_reg  <= (wx_next > SAT_MAX) ? SAT_MAX[23:0] :
                       (wx_next < SAT_MIN) ? SAT_MIN[23:0] : wx_next[23:0];
            wy_reg  <= (wy_next > SAT_MAX) ? SAT_MAX[23:0] :
                       (wy_next < SAT_MIN) ? SAT_MIN[23:0] : wy_next[23:0];
            wz_reg  <= (wz_next > SAT_MAX) ? SAT_MAX[23:0] :
                       (wz_next < SAT_MIN) ? SAT_MIN[23:0] : wz_next[23:0];
            rgb_reg <= {sum.blue, sum.green, sum.red};
        end
    end

    assign out_valid = out_valid_reg;
    assign world_x   = wx_reg;
    assign world_y   = wy_reg;
    assign world_z   = wz_reg;
    assign blue_out  = rgb_reg[23:16];
    assign green_out = rgb_reg[15:8];
    assign red_out   = rgb_reg[7:0];

    // ------------------------------------------------------------ assertions
    // zero-depth pixel leaves a bubble that reaches the camera stage empty
    a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && depth_mm == 16'd0) ##1 advance ##1 advance |=> !cam_valid)
        else $error("zero-depth pixel produced a camera point");

    // a stall freezes the internal valid bits
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cam_valid) && $stable(sum_valid))
        else $error("pipeline moved during a stall");

    // a new result only comes from the rotation stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(sum_valid))
        else $error("result appeared without a rotated point");

    // output register can only fill while the pipeline advances
    a_fill_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(advance))
        else $error("output register loaded without advance");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for depth_pixel_to_world_point. Pixels are pushed through
// the valid/ready input under varying idle patterns and camera settings. A
// fixed-point back-projection and rigid-transform predictor works out every
// world point, and the point checker compares each output transaction, field
// by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [9:0]  row;
        logic [9:0]  column;
        logic [15:0] depth;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } pixel_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } world_point_t;

    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;

    // ------------------------------------------------------------------------
    // Predictor and checker of world points
    // ------------------------------------------------------------------------
    class point_ledger;
        dpw_pkg::cfg_t camera;
        world_point_t  expected_points[$];
        int            mismatches;

        function new();
            camera.inv_fx      = 24'd27192;
            camera.inv_fy      = 24'd27136;
            camera.center      = 32'd248779771;
            camera.depth_limit = 16'd1200;
            camera.rot_x       = 48'd16384;
            camera.rot_y       = 48'd16384 << 16;
            camera.rot_z       = 48'd16384 << 32;
            camera.translation = '0;
            mismatches         = 0;
        endfunction

        // divide by 2^k, rounding half toward +infinity
        function longint round_shift(longint v, int k);
            return (v + (64'sd1 <<< (k - 1))) >>> k;
        endfunction

        function logic signed [23:0] rotate(logic [47:0] coef, longint cx, longint cy,
                                            longint cz, logic [20:0] offset);
            longint acc;
            acc = longint'($signed(coef[15:0])) * cx
                + longint'($signed(coef[31:16])) * cy
                + longint'($signed(coef[47:32])) * cz;
            acc = round_shift(acc, 14) + longint'($signed(offset));
            if (acc > COORD_MAX)
                acc = COORD_MAX;
            else if (acc < COORD_MIN)
                acc = COORD_MIN;
            return acc[23:0];
        endfunction

        function void note_pixel(pixel_t p);
            longint       dx;
            longint       dy;
            longint       cam_x;
            longint       cam_y;
            longint       cam_z;
            world_point_t w;
            // no measurement, or too far away: nothing comes out
            if (p.depth == 16'd0 || p.depth >= camera.depth_limit)
                return;
            dx    = longint'(p.column) * 16 - longint'(camera.center[15:0]);
            dy    = longint'(p.row) * 16 - longint'(camera.center[31:16]);
            cam_x = round_shift(dx * longint'(p.depth) * longint'(camera.inv_fx), 24);
            cam_y = round_shift(-dy * longint'(p.depth) * longint'(camera.inv_fy), 24);
            cam_z = longint'(p.depth) * 16;
            w.x     = rotate(camera.rot_x, cam_x, cam_y, cam_z, camera.translation[20:0]);
            w.y     = rotate(camera.rot_y, cam_x, cam_y, cam_z, camera.translation[41:21]);
            w.z     = rotate(camera.rot_z, cam_x, cam_y, cam_z, camera.translation[62:42]);
            w.blue  = p.blue;
            w.green = p.green;
            w.red   = p.red;
            expected_points.insert(expected_points.size(), w);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, longint got, longint want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_point(world_point_t got);
            world_point_t want;
            if (expected_points.size() == 0)
            begin
                report("output transaction with no point expected");
                return;
            end
            want = expected_points.pop_front();
            compare_field("world_x", got.x, want.x);
            compare_field("world_y", got.y, want.y);
            compare_field("world_z", got.z, want.z);
            compare_field("blue", got.blue, want.blue);
            compare_field("green", got.green, want.green);
            compare_field("red", got.red, want.red);
        endtask

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [62:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [9:0]         pixel_row;
    logic [9:0]         pixel_column;
    logic [15:0]        depth_mm;
    logic [7:0]         blue_in;
    logic [7:0]         green_in;
    logic [7:0]         red_in;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;

    point_ledger ledger;
    int          send_idle_pct;
    int          recv_idle_pct;

    depth_pixel_to_world_point dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .depth_mm     (depth_mm),
        .blue_in      (blue_in),
        .green_in     (green_in),
        .red_in       (red_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .world_x      (world_x),
        .world_y      (world_y),
        .world_z      (world_z),
        .blue_out     (blue_out),
        .green_out    (green_out),
        .red_out      (red_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                ledger.note_pixel('{pixel_row, pixel_column, depth_mm,
                                    blue_in, green_in, red_in});
            if (out_valid && out_ready)
                ledger.check_point('{world_x, world_y, world_z,
                                     blue_out, green_out, red_out});
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_pixel(pixel_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pixel_row    <= p.row;
        pixel_column <= p.column;
        depth_mm     <= p.depth;
        blue_in      <= p.blue;
        green_in     <= p.green;
        red_in       <= p.red;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending, let every point come out and the pipeline empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // all eight registers in index order; junk above each register's width
    task automatic program_camera(dpw_pkg::cfg_t c);
        logic [63:0] junk;
        logic [62:0] word;
        logic [2:0]  idx;
        for (int i = 0; i < 8; i++)
        begin
            junk = {$urandom, $urandom};
            word = junk[62:0];
            idx  = 3'(i);
            case (idx)
                dpw_pkg::REG_INV_FX: word[23:0] = c.inv_fx;
                dpw_pkg::REG_INV_FY: word[23:0] = c.inv_fy;
                dpw_pkg::REG_CENTER: word[31:0] = c.center;
                dpw_pkg::REG_DLIMIT: word[15:0] = c.depth_limit;
                dpw_pkg::REG_ROT_X:  word[47:0] = c.rot_x;
                dpw_pkg::REG_ROT_Y:  word[47:0] = c.rot_y;
                dpw_pkg::REG_ROT_Z:  word[47:0] = c.rot_z;
                dpw_pkg::REG_TRANS:  word       = c.translation;
                default: ;
            endcase
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        ledger.camera = c;
    endtask

    function automatic pixel_t make_pixel(int row, int column, int depth, int shade);
        pixel_t p;
        p.row    = row[9:0];
        p.column = column[9:0];
        p.depth  = depth[15:0];
        p.blue   = shade[7:0];
        p.green  = ~shade[7:0];
        p.red    = shade[7:0] ^ 8'h3C;
        return p;
    endfunction

    function automatic pixel_t random_pixel(logic [15:0] limit);
        pixel_t p;
        int     pick;
        p.row    = 10'($urandom_range(0, 1023));
        p.column = 10'($urandom_range(0, 1023));
        p.blue   = 8'($urandom);
        p.green  = 8'($urandom);
        p.red    = 8'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 8)
            p.depth = '0;
        else if (pick < 16 || limit < 16'd2)
            p.depth = 16'($urandom);
        else if (pick < 20)
            p.depth = limit - 16'($urandom_range(0, 1));
        else
            p.depth = 16'($urandom_range(1, int'(limit) - 1));
        return p;
    endfunction

    function automatic logic [47:0] random_rotation_row();
        logic [47:0] r;
        int          e;
        for (int j = 0; j < 3; j++)
        begin
            e = int'($urandom_range(0, 32768)) - 16384;
            r[16*j +: 16] = e[15:0];
        end
        return r;
    endfunction

    // plausible depth camera with an arbitrary pose
    function automatic dpw_pkg::cfg_t random_camera();
        dpw_pkg::cfg_t c;
        c.inv_fx      = 24'($urandom_range(15000, 40000));
        c.inv_fy      = 24'($urandom_range(15000, 40000));
        c.center      = {16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383))};
        c.depth_limit = 16'($urandom_range(500, 8000));
        c.rot_x       = random_rotation_row();
        c.rot_y       = random_rotation_row();
        c.rot_z       = random_rotation_row();
        c.translation = 63'({$urandom, $urandom});
        return c;
    endfunction

    function automatic dpw_pkg::cfg_t noise_camera();
        dpw_pkg::cfg_t c;
        c.inv_fx      = 24'($urandom);
        c.inv_fy      = 24'($urandom);
        c.center      = $urandom;
        c.depth_limit = 16'($urandom);
        c.rot_x       = 48'({$urandom, $urandom});
        c.rot_y       = 48'({$urandom, $urandom});
        c.rot_z       = 48'({$urandom, $urandom});
        c.translation = 63'({$urandom, $urandom});
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        dpw_pkg::cfg_t c;
        ledger        = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        pixel_row     = '0;
        pixel_column  = '0;
        depth_mm      = '0;
        blue_in       = '0;
        green_in      = '0;
        red_in        = '0;
        send_idle_pct = 30;
        recv_idle_pct = 83;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // default camera: corners, depth edges around the limit, colour extremes
        send_pixel(make_pixel(0, 0, 1, 0));
        send_pixel(make_pixel(1023, 1023, 1199, 255));
        send_pixel(make_pixel(512, 300, 0, 8'hAA));
        send_pixel(make_pixel(240, 320, 1200, 8'h55));
        send_pixel(make_pixel(240, 320, 1201, 8'h0F));
        send_pixel(make_pixel(700, 100, 65535, 8'hF0));
        send_pixel(make_pixel(240, 320, 600, 8'h55));
        send_pixel(make_pixel(0, 1023, 1000, 8'hAA));
        send_pixel(make_pixel(1023, 0, 32768, 8'hFF));
        wait_drained();

        // largest gains and rotation entries: drive some coordinates into saturation
        c.inv_fx      = '1;
        c.inv_fy      = '1;
        c.center      = '0;
        c.depth_limit = '1;
        c.rot_x       = {3{16'h8000}};
        c.rot_y       = {3{16'h7FFF}};
        c.rot_z       = {16'h7FFF, 16'h8000, 16'h7FFF};
        c.translation = {21'h0FFFFF, 21'h100000, 21'h0FFFFF};
        program_camera(c);
        send_pixel(make_pixel(1023, 1023, 65534, 1));
        send_pixel(make_pixel(0, 0, 65534, 2));
        send_pixel(make_pixel(0, 0, 65535, 3));
        send_pixel(make_pixel(1023, 0, 1, 4));
        send_pixel(make_pixel(0, 1023, 40000, 5));
        wait_drained();

        c.center      = '1;
        c.rot_x       = {3{16'h7FFF}};
        c.rot_y       = {3{16'h8000}};
        c.translation = {21'h100000, 21'h0FFFFF, 21'h100000};
        program_camera(c);
        send_pixel(make_pixel(1023, 1023, 65534, 6));
        send_pixel(make_pixel(0, 0, 65534, 7));
        send_pixel(make_pixel(512, 512, 2, 8));
        wait_drained();

        // zero depth limit drops every pixel
        c.depth_limit = '0;
        program_camera(c);
        send_pixel(make_pixel(10, 10, 1, 9));
        send_pixel(make_pixel(10, 10, 65535, 10));
        send_pixel(make_pixel(1023, 1023, 100, 11));
        wait_drained();

        for (int batch = 0; batch < 10; batch++)
        begin
            if (batch == 4)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 30;
            end
            else if (batch == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (batch)
                2:
                begin
                    // no gain and no rotation: the point is the translation alone
                    c             = noise_camera();
                    c.inv_fx      = '0;
                    c.inv_fy      = '0;
                    c.depth_limit = '1;
                    c.rot_x       = '0;
                    c.rot_y       = '0;
                    c.rot_z       = '0;
                end
                6:
                begin
                    c             = noise_camera();
                    c.inv_fx      = '1;
                    c.inv_fy      = '1;
                    c.depth_limit = '1;
                end
                1, 5, 9: c = noise_camera();
                default: c = random_camera();
            endcase
            program_camera(c);
            for (int n = 0; n < 100; n++)
            begin
                if (batch == 5 && n == 50)
                    wait_drained();
                send_pixel(random_pixel(c.depth_limit));
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (ledger.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/dpw_pkg.sv
design/dpw_cam.sv
design/dpw_rigid.sv
design/depth_pixel_to_world_point.sv
tb/sv/tb_top.sv
